// ===== sv/mkpc_pkg.sv =====
package mkpc_pkg;

  localparam int NUM_KEYS  = 3;
  localparam int TIME_BITS = 32;

  // fixed field widths
  localparam int NOW_BITS      = 32;
  localparam int KEY_NUM_BITS  = 2;
  localparam int THRESH_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HOLD_THRESH    = 2'd0,
    REG_EVENTS_ENABLED = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    KIND_SHORT = 1'b0,
    KIND_LONG  = 1'b1
  } evt_kind_t;

  typedef struct packed {
    logic                read_ok;
    logic [NUM_KEYS-1:0] key_levels;
    logic [NOW_BITS-1:0] now_ms;
  } scan_t;

  typedef struct packed {
    logic [KEY_NUM_BITS-1:0] key_number;
    logic                    event_kind;
    logic                    last_of_scan;
  } evt_t;

  // what one lane found for the current scan
  typedef struct packed {
    logic fire;
    logic kind;
  } lane_ev_t;

endpackage

// ===== sv/multi_key_press_classifier.sv =====
// multi-key press classifier
// scan channel (scan_valid/scan_ready/scan_data): one beat per key scan with
//   the active-low key levels, a millisecond timestamp and a read-ok flag;
//   a beat with read_ok low is taken and changes nothing
// event channel (evt_valid/evt_ready/evt_data): one beat per short or long
//   press, in key order, last_of_scan set on the final beat of a scan
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready,
//   index 0 = hold threshold in ms, 1 = events_enabled, other indexes ignored
// event path: the first event of a scan goes from the pending set register
//   to the output register before it is on evt_valid
// throughput: one cycle per scan that yields no event; a scan with k events
//   holds scan_ready low until the per-key pending set has drained, since
//   the merge stage moves one event per cycle into the output register
// a stalled receiver stops the drain; the held output register still lets
//   a new scan be taken once the pending set is empty
// reset: no key pressed, start times zero, hold threshold = 1000 ms,
//   events off
module multi_key_press_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              scan_valid,
  output logic                              scan_ready,
  input  mkpc_pkg::scan_t                   scan_data,
  output logic                              evt_valid,
  input  logic                              evt_ready,
  output mkpc_pkg::evt_t                    evt_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mkpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mkpc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import mkpc_pkg::*;

  logic [THRESH_BITS-1:0] hold_thresh;
  logic                   events_enabled;

  logic                   busy;
  logic                   accept;
  logic                   step;
  logic [TIME_BITS-1:0]   now;
  lane_ev_t               ev [NUM_KEYS];

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_thresh    <= LONG_PRESS_RESET;
      events_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD_THRESH:    hold_thresh    <= cfg_data;
        REG_EVENTS_ENABLED: events_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a scan is taken only when no event of an earlier scan is still pending
  assign scan_ready = ~busy;
  assign accept     = scan_valid & scan_ready;
  assign step       = accept & scan_data.read_ok;
  assign now        = TIME_BITS'(scan_data.now_ms);

  // one lane per key, all keys classified in the accept cycle
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    mkpc_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .step           (step),
      .level          (scan_data.key_levels[k]),
      .now            (now),
      .hold_thresh    (hold_thresh),
      .events_enabled (events_enabled),
      .ev             (ev[k])
    );
  end

  // serializes the lane results onto the event channel
  mkpc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .ev        (ev),
    .busy      (busy),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt_data  (evt_data)
  );

`ifndef SYNTH
  // nothing becomes pending from a scan taken while events are off
  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && !events_enabled) |=> !busy)
    else $error("event pending after scan taken with events disabled");

  // a beat that is not the last of its scan has more events behind it
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_data.last_of_scan) |-> busy)
    else $error("non-final event with nothing pending");

  // events name a real key
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> (32'(evt_data.key_number) < NUM_KEYS))
    else $error("event key number out of range");
`endif

endmodule

// ===== sv/mkpc_lane.sv =====
module mkpc_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                level,
  input  logic [mkpc_pkg::TIME_BITS-1:0]      now,
  input  logic [mkpc_pkg::THRESH_BITS-1:0]    hold_thresh,
  input  logic                                events_enabled,
  output mkpc_pkg::lane_ev_t                  ev
);
  import mkpc_pkg::*;

  logic                 was_pressed;
  logic                 long_fired;
  logic [TIME_BITS-1:0] press_start_time;

  logic                 pressed;
  logic [TIME_BITS-1:0] held;
  logic                 below;
  logic                 fire_short;
  logic                 fire_long;

  assign pressed    = ~level;
  assign held       = now - press_start_time;
  assign below      = held < TIME_BITS'(hold_thresh);
  assign fire_short = step & ~pressed & was_pressed & below & ~long_fired & events_enabled;
  assign fire_long  = step & pressed & was_pressed & ~long_fired & ~below & events_enabled;

  assign ev.fire = fire_short | fire_long;
  assign ev.kind = fire_long ? KIND_LONG : KIND_SHORT;

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed      <= 1'b0;
      long_fired       <= 1'b0;
      press_start_time <= '0;
    end else if (step) begin
      was_pressed <= pressed;
      if (pressed && !was_pressed) begin
        press_start_time <= now;
        long_fired       <= 1'b0;
      end else if (fire_long) begin
        long_fired <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/mkpc_merge.sv =====
module mkpc_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  mkpc_pkg::lane_ev_t    ev [mkpc_pkg::NUM_KEYS],
  output logic                  busy,
  output logic                  evt_valid,
  input  logic                  evt_ready,
  output mkpc_pkg::evt_t        evt_data
);
  import mkpc_pkg::*;

  logic [NUM_KEYS-1:0] pend;
  logic [NUM_KEYS-1:0] pend_next;
  logic [NUM_KEYS-1:0] kinds;
  logic [KIDX_W-1:0]   sel;
  logic                move;

  // lowest pending key goes first
  always_comb begin
    sel = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pend[i]) sel = KIDX_W'(i);
    end
  end

  assign move = (pend != '0) && (!evt_valid || evt_ready);

  always_comb begin
    pend_next = pend;
    if (move) pend_next[sel] = 1'b0;
  end

  assign busy = pend != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      evt_valid <= 1'b0;
    end else begin
      if (load) begin
        for (int i = 0; i < NUM_KEYS; i++) pend[i] <= ev[i].fire;
      end else begin
        pend <= pend_next;
      end
      if (move) evt_valid <= 1'b1;
      else if (evt_ready) evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_KEYS; i++) kinds[i] <= ev[i].kind;
    end
    if (move) begin
      evt_data.key_number   <= KEY_NUM_BITS'(sel);
      evt_data.event_kind   <= kinds[sel];
      evt_data.last_of_scan <= pend_next == '0;
    end
  end

endmodule
